// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ===== rtl/sbq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbq_pkg
// Types and constants for the stereo biquad filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbq_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int COEF_W          = 32;
    localparam int HIST_W          = 41;
    localparam int CFG_INDEX_W     = 3;
    localparam int SBQ_QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FF_COEF_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FF_COEF_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FF_COEF_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FB_COEF_1 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FB_COEF_2 = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } sbq_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } sbq_out_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] ff_coef_0;
        logic signed [COEF_W-1:0] ff_coef_1;
        logic signed [COEF_W-1:0] ff_coef_2;
        logic signed [COEF_W-1:0] fb_coef_1;
        logic signed [COEF_W-1:0] fb_coef_2;
    } sbq_coef_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
        logic acc_en;
        logic commit;
    } sbq_ctrl_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_SUM,
        SEQ_ACC,
        SEQ_RND
    } sbq_seq_t;

endpackage

// ===== rtl/sbq_queue.sv =====
// ----------------------------------------------------------------------------
// sbq_queue
// Small frame queue between the input channel and the filter engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbq_queue #(
    parameter int DEPTH = sbq_pkg::SBQ_QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sbq_pkg::sbq_in_t s_data,
    output logic            q_valid,
    input  logic            q_pop,
    output sbq_pkg::sbq_in_t q_data
);
    import sbq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sbq_in_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;

    assign s_ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_data;
        end
    end

endmodule

// ===== rtl/sbq_lane.sv =====
// ----------------------------------------------------------------------------
// sbq_lane
// One channel of the Direct Form I biquad: products, partial sums,
// accumulator, rounding, saturation and history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbq_lane (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sbq_pkg::sbq_coef_t                coef,
    input  sbq_pkg::sbq_ctrl_t                ctrl,
    input  logic signed [sbq_pkg::SAMPLE_W-1:0] x_in,
    output logic signed [sbq_pkg::SAMPLE_W-1:0] y_out
);
    import sbq_pkg::*;

    localparam logic [64:0] RND40_HALF = 65'h80_0000_0000;
    localparam logic [64:0] RND24_HALF = 65'h80_0000;

    // history
    logic signed [SAMPLE_W-1:0] x_reg, x1_reg, x2_reg;
    logic signed [HIST_W-1:0]   y1_reg, y2_reg;

    // product stage
    logic signed [47:0] p0_reg, p1_reg, p2_reg;
    logic signed [55:0] q1l_reg, q2l_reg;
    logic signed [48:0] q1h_reg, q2h_reg;
    logic signed [47:0] p0_next, p1_next, p2_next;
    logic signed [55:0] q1l_next, q2l_next;
    logic signed [48:0] q1h_next, q2h_next;

    // partial sums
    logic signed [49:0] fwd_reg, fwd_next;
    logic signed [56:0] fbl_reg, fbl_next;
    logic signed [49:0] fbh_reg, fbh_next;

    // accumulator and rounding
    logic [63:0]        acc_reg, acc_next;
    logic [63:0]        fbl_ext;
    logic               neg;
    logic [64:0]        rnd40, rnd24;
    logic signed [24:0] v40;
    logic signed [HIST_W-1:0] y_new;

    always_comb begin
        p0_next  = coef.ff_coef_0 * x_in;
        p1_next  = coef.ff_coef_1 * x1_reg;
        p2_next  = coef.ff_coef_2 * x2_reg;
        q1l_next = coef.fb_coef_1 * $signed({1'b0, y1_reg[23:0]});
        q2l_next = coef.fb_coef_2 * $signed({1'b0, y2_reg[23:0]});
        q1h_next = coef.fb_coef_1 * $signed(y1_reg[HIST_W-1:24]);
        q2h_next = coef.fb_coef_2 * $signed(y2_reg[HIST_W-1:24]);
    end

    always_comb begin
        fwd_next = 50'(p0_reg) + 50'(p1_reg) + 50'(p2_reg);
        fbl_next = 57'(q1l_reg) + 57'(q2l_reg);
        fbh_next = 50'(q1h_reg) + 50'(q2h_reg);
    end

    // all terms wrap modulo 2^64
    always_comb begin
        fbl_ext  = 64'(fbl_reg);
        acc_next = {fwd_reg[47:0], 16'b0} - fbl_ext - {fbh_reg[39:0], 24'b0};
    end

    // half away from zero: negative values take a bias one below the half
    always_comb begin
        neg   = acc_reg[63];
        rnd40 = {acc_reg[63], acc_reg} + (neg ? (RND40_HALF - 65'd1) : RND40_HALF);
        rnd24 = {acc_reg[63], acc_reg} + (neg ? (RND24_HALF - 65'd1) : RND24_HALF);
        v40   = $signed(rnd40[64:40]);
        y_new = $signed(rnd24[64:24]);
        if (v40 > 25'sd32767) begin
            y_out = 16'sh7fff;
        end else if (v40 < -25'sd32768) begin
            y_out = -16'sh8000;
        end else begin
            y_out = v40[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            x_reg   <= x_in;
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            q1l_reg <= q1l_next;
            q2l_reg <= q2l_next;
            q1h_reg <= q1h_next;
            q2h_reg <= q2h_next;
        end
        if (ctrl.sum_en) begin
            fwd_reg <= fwd_next;
            fbl_reg <= fbl_next;
            fbh_reg <= fbh_next;
        end
        if (ctrl.acc_en) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end else if (ctrl.commit) begin
            x2_reg <= x1_reg;
            x1_reg <= x_reg;
            y2_reg <= y1_reg;
            y1_reg <= y_new;
        end
    end

endmodule

// ===== rtl/sbq_engine.sv =====
// ----------------------------------------------------------------------------
// sbq_engine
// Back end: sequences one frame through both channel lanes and holds
// the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbq_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  sbq_pkg::sbq_coef_t coef,
    input  logic              q_valid,
    output logic              q_pop,
    input  sbq_pkg::sbq_in_t  q_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sbq_pkg::sbq_out_t m_data
);
    import sbq_pkg::*;

    sbq_seq_t  state_reg, state_next;
    sbq_ctrl_t ctrl;
    logic      out_free;
    logic      m_valid_reg;
    sbq_out_t  m_data_reg;
    logic signed [SAMPLE_W-1:0] left_y, right_y;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (q_valid) begin
                    state_next = SEQ_MUL;
                end
            end
            SEQ_MUL: state_next = SEQ_SUM;
            SEQ_SUM: state_next = SEQ_ACC;
            SEQ_ACC: state_next = SEQ_RND;
            SEQ_RND: begin
                if (out_free) begin
                    state_next = q_valid ? SEQ_MUL : SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_comb begin
        ctrl.mul_en = (state_reg == SEQ_MUL);
        ctrl.sum_en = (state_reg == SEQ_SUM);
        ctrl.acc_en = (state_reg == SEQ_ACC);
        ctrl.commit = (state_reg == SEQ_RND) && out_free;
        q_pop       = ctrl.mul_en;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    sbq_lane u_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .coef    (coef),
        .ctrl    (ctrl),
        .x_in    (q_data.left_in),
        .y_out   (left_y)
    );

    sbq_lane u_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .coef    (coef),
        .ctrl    (ctrl),
        .x_in    (q_data.right_in),
        .y_out   (right_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            m_data_reg.left_out  <= left_y;
            m_data_reg.right_out <= right_y;
        end
    end

    `ASSERT_PROP(a_pop_has_data, aclk, aresetn, q_pop |-> q_valid, "pop from empty queue")
    `ASSERT_PROP(a_mul_then_sum, aclk, aresetn, (state_reg == SEQ_MUL) |=> (state_reg == SEQ_SUM), "sequence skipped")
    `ASSERT_NEVER(a_no_overwrite, aclk, aresetn, ctrl.commit && m_valid_reg && !m_ready, "result overwritten")
    `ASSERT_PROP(a_commit_shows, aclk, aresetn, ctrl.commit |=> m_valid_reg, "committed result not shown")

endmodule

// ===== rtl/stereo_biquad_q24_int16_core.sv =====
// ----------------------------------------------------------------------------
// stereo_biquad_q24_int16_core
// Stereo second-order IIR section, Q24 coefficients, int16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data take one stereo frame per transfer.
//   m_valid/m_ready/m_data deliver one filtered frame per input frame.
//   cfg_wr_en/cfg_index/cfg_wdata write the five coefficients while idle;
//   indices beyond the list are ignored.
// Timing:
//   A frame is queued, then runs multiply, partial sum, accumulate and
//   round in order; the round step commits the result to m_data and
//   m_valid. A new frame starts only after the last one commits, since
//   the recursion through the output history must be rounded before the
//   next multiply.
//   The input queue keeps taking frames while the engine works.
// Reset:
//   Clears coefficients, channel history, the queue and the output valid.
// Stall:
//   A held result blocks the next commit; the engine waits in the round
//   step and the queue fills, then s_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_biquad_q24_int16_core #(
    parameter int QUEUE_DEPTH = sbq_pkg::SBQ_QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sbq_pkg::sbq_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sbq_pkg::sbq_out_t                   m_data,
    input  logic                                cfg_wr_en,
    input  logic [sbq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sbq_pkg::COEF_W-1:0]          cfg_wdata
);
    import sbq_pkg::*;

    sbq_coef_t coef_reg;
    logic      q_valid;
    logic      q_pop;
    sbq_in_t   q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FF_COEF_0: coef_reg.ff_coef_0 <= cfg_wdata;
                REG_FF_COEF_1: coef_reg.ff_coef_1 <= cfg_wdata;
                REG_FF_COEF_2: coef_reg.ff_coef_2 <= cfg_wdata;
                REG_FB_COEF_1: coef_reg.fb_coef_1 <= cfg_wdata;
                REG_FB_COEF_2: coef_reg.fb_coef_2 <= cfg_wdata;
                default: ;
            endcase
        end
    end

    sbq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data)
    );

    sbq_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .coef    (coef_reg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
